### hdl/deadline_event_queue_assert.svh
// assertion macros shared by the deadline event queue modules
`ifndef DEADLINE_EVENT_QUEUE_ASSERT_SVH
`define DEADLINE_EVENT_QUEUE_ASSERT_SVH

// condition holds at every edge out of reset
`define DLEQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dleq: invariant violated");

// consequent holds in the same cycle as the antecedent
`define DLEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dleq: same-cycle implication violated");

// consequent holds in the cycle after the antecedent
`define DLEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dleq: next-cycle implication violated");

`endif

### hdl/dleq_pkg.sv
// package with item types, codes and control structs of the deadline event queue
`timescale 1ns / 1ps

package dleq_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 4;
    localparam int TIME_W    = 64;
    // slot numbers are 4 bits wide, so at most this many entries are ever queued
    localparam int MAX_QUEUE = 16;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_READD = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] event_id_res;
        logic            last;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       unlink;
        logic       insert;
        logic       pop;
        logic       emit;
        logic [1:0] kind;
        logic       from_head;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       id_ok;
        logic       no_interval;
        logic       head_exp;
        logic       next_exp;
        logic       res_free;
    } dp_status_t;

endpackage

### hdl/deadline_event_queue.sv
// top level of the deadline-ordered timer event queue
`timescale 1ns / 1ps

// timer event queue kept in deadline order, one entry per event slot. an add item
// takes the slot off the queue if present, stores its timeout as the slot interval
// and queues it with deadline now + timeout (64-bit wrap), behind every entry with
// an equal or earlier deadline; a re-add does the same but a zero timeout reuses the
// stored interval, and with no stored interval the slot stays off the queue and the
// result item is a reject. add and re-add give exactly one result item (last = 1).
// a tick item emits, in queue order, one result item per expired entry (deadline at
// or before now) and dequeues it; with nothing expired it gives no result. mode 3 is
// ignored. steps: add and re-add go through accept, unlink pass and insert pass, the
// reject for a slot number not below SLOTS follows accept directly; a tick goes
// through accept and a decode step, then expiry steps, one per expired event or one
// when nothing expires; mode 3 ends after the decode step. the sorted shift queue
// moves every entry by at most one position per cycle; a stalled result port holds
// the sequence. one item is in flight at a time. the queue holds min(SLOTS, 16)
// entries, the interval store SLOTS entries; all state is empty after reset with no clearing pass
module deadline_event_queue #(
    parameter int SLOTS = dleq_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  dleq_pkg::in_item_t  op,
    output logic                res_valid,
    input  logic                res_ready,
    output dleq_pkg::out_item_t res
);

    // command and status between sequencer and datapath
    dleq_pkg::dp_cmd_t    cmd;
    dleq_pkg::dp_status_t status;

    dleq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // result register parts the queue from the downstream port
    dleq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### hdl/dleq_dpath.sv
// datapath: item register, sorted shift queue, interval memory and result register
`timescale 1ns / 1ps
`include "deadline_event_queue_assert.svh"

module dleq_dpath #(
    parameter int SLOTS = dleq_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dleq_pkg::in_item_t   op,
    input  logic                 res_ready,
    output logic                 res_valid,
    output dleq_pkg::out_item_t  res,
    input  dleq_pkg::dp_cmd_t    cmd,
    output dleq_pkg::dp_status_t status
);

    localparam int QD = (SLOTS < dleq_pkg::MAX_QUEUE) ? SLOTS : dleq_pkg::MAX_QUEUE;
    localparam int SIDX_W = $clog2(SLOTS);
    localparam int IDX_EXT_W = (SIDX_W > dleq_pkg::ID_W) ? SIDX_W : dleq_pkg::ID_W;

    dleq_pkg::in_item_t            item_reg;

    logic [dleq_pkg::TIME_W-1:0]   q_deadline_reg [QD];
    logic [dleq_pkg::ID_W-1:0]     q_slot_reg     [QD];
    logic [QD-1:0]                 q_valid_reg;
    logic [dleq_pkg::TIME_W-1:0]   q_deadline_next [QD];
    logic [dleq_pkg::ID_W-1:0]     q_slot_next     [QD];
    logic [QD-1:0]                 q_valid_next;

    logic [dleq_pkg::TIME_W-1:0]   ivl_mem [SLOTS];
    logic [SLOTS-1:0]              ivl_valid_reg;
    logic [dleq_pkg::TIME_W-1:0]   ivl_rd_reg;
    logic                          ivl_rd_ok_reg;

    logic                          res_valid_reg;
    dleq_pkg::out_item_t           res_reg;

    logic [IDX_EXT_W-1:0]          id_ext;
    logic [SIDX_W-1:0]             id_idx;
    logic                          id_ok;
    logic [dleq_pkg::TIME_W-1:0]   stored_ivl;
    logic [dleq_pkg::TIME_W-1:0]   eff_ivl;
    logic [dleq_pkg::TIME_W-1:0]   new_deadline;
    logic                          no_interval;
    logic                          head_exp;
    logic                          next_exp;
    logic [QD-1:0]                 match;
    logic [QD-1:0]                 hit_upto;
    logic [QD-1:0]                 gt;

    assign id_ext = IDX_EXT_W'(item_reg.event_id);
    assign id_idx = id_ext[SIDX_W-1:0];
    assign id_ok  = 32'(item_reg.event_id) < SLOTS;

    // zero timeout on re-add falls back to the stored interval
    assign stored_ivl   = ivl_rd_ok_reg ? ivl_rd_reg : '0;
    assign eff_ivl      = (item_reg.mode == dleq_pkg::MODE_READD && item_reg.timeout == '0)
                          ? stored_ivl : item_reg.timeout;
    assign no_interval  = (item_reg.mode == dleq_pkg::MODE_READD) && (eff_ivl == '0);
    assign new_deadline = item_reg.now + eff_ivl;

    assign head_exp = q_valid_reg[0] && (q_deadline_reg[0] <= item_reg.now);
    assign next_exp = q_valid_reg[1] && (q_deadline_reg[1] <= item_reg.now);

    always_comb
    begin
        logic [QD-1:0] upto;
        upto = '0;
        q_deadline_next = q_deadline_reg;
        q_slot_next     = q_slot_reg;
        q_valid_next    = q_valid_reg;
        for (int i = 0; i < QD; i++)
        begin
            match[i] = q_valid_reg[i] && (q_slot_reg[i] == item_reg.event_id);
            // empty cells count as later, so the new entry lands at the tail
            gt[i]    = !q_valid_reg[i] || (q_deadline_reg[i] > new_deadline);
        end
        for (int i = 0; i < QD; i++)
        begin
            upto        = match << (QD - 1 - i);
            hit_upto[i] = |upto;
        end
        if (cmd.unlink || cmd.pop)
        begin
            for (int i = 0; i < QD - 1; i++)
            begin
                if (cmd.pop || hit_upto[i])
                begin
                    q_deadline_next[i] = q_deadline_reg[i+1];
                    q_slot_next[i]     = q_slot_reg[i+1];
                    q_valid_next[i]    = q_valid_reg[i+1];
                end
            end
            if (cmd.pop || hit_upto[QD-1])
            begin
                q_valid_next[QD-1] = 1'b0;
            end
        end
        else if (cmd.insert && !q_valid_reg[QD-1])
        begin
            if (gt[0])
            begin
                q_deadline_next[0] = new_deadline;
                q_slot_next[0]     = item_reg.event_id;
                q_valid_next[0]    = 1'b1;
            end
            for (int i = 1; i < QD; i++)
            begin
                if (gt[i] && !gt[i-1])
                begin
                    q_deadline_next[i] = new_deadline;
                    q_slot_next[i]     = item_reg.event_id;
                    q_valid_next[i]    = 1'b1;
                end
                else if (gt[i])
                begin
                    q_deadline_next[i] = q_deadline_reg[i-1];
                    q_slot_next[i]     = q_slot_reg[i-1];
                    q_valid_next[i]    = q_valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg   <= '0;
            ivl_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
            if (cmd.insert)
            begin
                ivl_valid_reg[id_idx] <= 1'b1;
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= op;
        end
        q_deadline_reg <= q_deadline_next;
        q_slot_reg     <= q_slot_next;
        if (cmd.emit)
        begin
            res_reg.kind         <= cmd.kind;
            res_reg.event_id_res <= cmd.from_head ? q_slot_reg[0] : item_reg.event_id;
            res_reg.last         <= cmd.from_head ? !next_exp : 1'b1;
        end
    end

    // interval memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            ivl_mem[id_idx] <= eff_ivl;
        end
        ivl_rd_reg    <= ivl_mem[id_idx];
        ivl_rd_ok_reg <= ivl_valid_reg[id_idx];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign status.mode        = item_reg.mode;
    assign status.id_ok       = id_ok;
    assign status.no_interval = no_interval;
    assign status.head_exp    = head_exp;
    assign status.next_exp    = next_exp;
    assign status.res_free    = !res_valid_reg || res_ready;

    `DLEQ_ASSERT_ALWAYS(a_valid_prefix, clk, rst_n, ((q_valid_reg >> 1) & ~q_valid_reg) == '0)
    `DLEQ_ASSERT_NXT(a_insert_grows, clk, rst_n, cmd.insert, $countones(q_valid_reg) == $past($countones(q_valid_reg)) + 1)
    `DLEQ_ASSERT_NXT(a_pop_shrinks, clk, rst_n, cmd.pop, $countones(q_valid_reg) + 1 == $past($countones(q_valid_reg)))

endmodule

### hdl/dleq_ctrl.sv
// controller state machine that sequences unlink, insert and expiry passes
`timescale 1ns / 1ps
`include "deadline_event_queue_assert.svh"

module dleq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_ready,
    input  dleq_pkg::dp_status_t status,
    output dleq_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNLINK,
        S_INSERT,
        S_TICK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        op_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                unique case (status.mode) inside
                    dleq_pkg::MODE_ADD, dleq_pkg::MODE_READD:
                    begin
                        if (!status.id_ok)
                        begin
                            if (status.res_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.kind   = dleq_pkg::KIND_REJECT;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.unlink = 1'b1;
                            state_next = S_INSERT;
                        end
                    end
                    dleq_pkg::MODE_TICK:
                    begin
                        state_next = S_TICK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INSERT:
            begin
                if (status.res_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.no_interval)
                    begin
                        cmd.kind = dleq_pkg::KIND_REJECT;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        cmd.kind   = dleq_pkg::KIND_ACCEPT;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (!status.head_exp)
                begin
                    state_next = S_IDLE;
                end
                else if (status.res_free)
                begin
                    cmd.pop       = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.kind      = dleq_pkg::KIND_EXPIRED;
                    cmd.from_head = 1'b1;
                    if (!status.next_exp)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DLEQ_ASSERT_IMP(a_emit_has_room, clk, rst_n, cmd.emit, status.res_free)
    `DLEQ_ASSERT_IMP(a_pop_only_expired, clk, rst_n, cmd.pop, status.head_exp)
    `DLEQ_ASSERT_IMP(a_insert_valid_id, clk, rst_n, cmd.insert, status.id_ok && !status.no_interval)

endmodule

### tb/tb_top.sv
// self-checking testbench for the deadline-ordered timer event queue
`timescale 1ns / 1ps

module tb_top;

    // mode code that the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // software copy of the queue and the list of results still owed by the block
    class event_queue_board;
        logic [63:0]         dl_q [dleq_pkg::MAX_QUEUE];
        logic [3:0]          slot_q [dleq_pkg::MAX_QUEUE];
        int                  depth;
        logic [63:0]         interval [dleq_pkg::SLOTS_DEF];
        dleq_pkg::out_item_t due_results [$];
        int                  errors;

        function new();
            depth = 0;
            errors = 0;
            foreach (dl_q[i])
            begin
                dl_q[i] = '0;
                slot_q[i] = '0;
            end
            foreach (interval[i])
                interval[i] = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // close the gap left by an entry, everything behind moves up one place
        function void drop_at(int pos);
            for (int i = pos; i + 1 < depth; i++)
            begin
                dl_q[i] = dl_q[i + 1];
                slot_q[i] = slot_q[i + 1];
            end
            dl_q[depth - 1] = '0;
            slot_q[depth - 1] = '0;
            depth--;
        endfunction

        function void unqueue(logic [3:0] s);
            for (int i = 0; i < depth; i++)
            begin
                if (slot_q[i] == s)
                begin
                    drop_at(i);
                    return;
                end
            end
        endfunction

        // insert behind every entry with an equal or earlier deadline
        function void enqueue(logic [3:0] s, logic [63:0] ivl, logic [63:0] t_now);
            logic [63:0] dl;
            int pos;
            dl = t_now + ivl;
            unqueue(s);
            interval[s] = ivl;
            if (depth >= dleq_pkg::MAX_QUEUE)
                return;
            pos = 0;
            while (pos < depth && dl_q[pos] <= dl)
                pos++;
            for (int i = depth; i > pos; i--)
            begin
                dl_q[i] = dl_q[i - 1];
                slot_q[i] = slot_q[i - 1];
            end
            dl_q[pos] = dl;
            slot_q[pos] = s;
            depth++;
        endfunction

        // apply one accepted item and queue the results it owes
        function void record_op(dleq_pkg::in_item_t it);
            dleq_pkg::out_item_t r;
            logic [63:0]         ivl;
            int                  n;
            case (it.mode)
                dleq_pkg::MODE_ADD, dleq_pkg::MODE_READD:
                begin
                    r.kind = dleq_pkg::KIND_ACCEPT;
                    r.event_id_res = it.event_id;
                    r.last = 1'b1;
                    if (int'(it.event_id) >= dleq_pkg::SLOTS_DEF)
                        r.kind = dleq_pkg::KIND_REJECT;
                    else if (it.mode == dleq_pkg::MODE_ADD)
                        enqueue(it.event_id, it.timeout, it.now);
                    else
                    begin
                        unqueue(it.event_id);
                        ivl = (it.timeout != '0) ? it.timeout : interval[it.event_id];
                        if (ivl == '0)
                            r.kind = dleq_pkg::KIND_REJECT;
                        else
                            enqueue(it.event_id, ivl, it.now);
                    end
                    due_results.push_back(r);
                end
                dleq_pkg::MODE_TICK:
                begin
                    n = 0;
                    while (n < dleq_pkg::MAX_QUEUE && depth > 0 && dl_q[0] <= it.now)
                    begin
                        r.kind = dleq_pkg::KIND_EXPIRED;
                        r.event_id_res = slot_q[0];
                        r.last = 1'b0;
                        due_results.push_back(r);
                        drop_at(0);
                        n++;
                    end
                    if (n > 0)
                    begin
                        r = due_results.pop_back();
                        r.last = 1'b1;
                        due_results.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_res(dleq_pkg::out_item_t got);
            dleq_pkg::out_item_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d slot %0d last %0d",
                         $time, got.kind, got.event_id_res, got.last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.kind != want.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.event_id_res != want.event_id_res)
            begin
                $display("%0t: slot expected %0d actual %0d",
                         $time, want.event_id_res, got.event_id_res);
                errors++;
            end
            if (got.last != want.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                op_valid = 1'b0;
    logic                op_ready;
    dleq_pkg::in_item_t  op = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    dleq_pkg::out_item_t res;

    event_queue_board sb = new();

    // sender burst bookkeeping and the one-time request for a long receiver hold-off
    int   burst_left = 0;
    logic hold_req = 1'b0;

    deadline_event_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard limit, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // results are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_res(res);
    end

    // receiver: phases with their own stall rate, plus one long hold-off on request
    initial
    begin : result_sink
        int   phase_left;
        int   stall_pct;
        logic hold_taken;
        phase_left = 0;
        stall_pct = 0;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                // block keeps its one result pending, so its input backs up
                res_ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_taken = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                phase_left--;
                res_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // offer one item; called at a falling edge, returns at the falling edge after
    // acceptance with valid still high so back-to-back items need no bubble
    task automatic offer(input logic [1:0] m, input logic [3:0] id,
                         input logic [63:0] tmo, input logic [63:0] t_now);
        dleq_pkg::in_item_t it;
        int                 gap;
        it.mode = m;
        it.event_id = id;
        it.timeout = tmo;
        it.now = t_now;
        if (burst_left == 0)
        begin
            // half the bursts follow the previous one with no gap at all
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                op_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        op <= it;
        op_valid <= 1'b1;
        do
            @(posedge clk);
        while (!op_ready);
        sb.record_op(it);
        burst_left--;
        @(negedge clk);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic drain();
        op_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    initial
    begin : stimulus
        logic [63:0] clock_us;
        int          items_done;
        int          pick;
        logic        hold_issued;
        clock_us = '0;
        items_done = 0;
        hold_issued = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, '0);                // tick on empty queue
        offer(MODE_UNUSED, 4'd9, TIME_MAX, TIME_MAX);            // ignored mode
        offer(dleq_pkg::MODE_READD, 4'd5, '0, 64'd10);           // no interval stored
        offer(dleq_pkg::MODE_ADD, 4'd0, '0, '0);                 // zero timeout
        offer(dleq_pkg::MODE_ADD, 4'd15, TIME_MAX, TIME_MAX);    // deadline wraps
        offer(dleq_pkg::MODE_ADD, 4'd3, 64'd100, 64'd1000);
        offer(dleq_pkg::MODE_ADD, 4'd4, 64'd100, 64'd1000);      // equal, goes behind
        offer(dleq_pkg::MODE_ADD, 4'd7, 64'd1100, '0);           // equal again
        offer(dleq_pkg::MODE_ADD, 4'd3, 64'd50, 64'd1000);       // queued, moved up
        offer(dleq_pkg::MODE_READD, 4'd4, '0, 64'd2000);         // reuse stored interval
        offer(dleq_pkg::MODE_READD, 4'd7, 64'd5, 64'd1000);      // new interval
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, '0);                // deadline equal to now
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, 64'd1004);          // nothing due
        offer(dleq_pkg::MODE_TICK, 4'd15, TIME_MAX, 64'd1100);   // two due
        offer(dleq_pkg::MODE_READD, 4'd0, '0, 64'd5);            // stored interval zero
        offer(dleq_pkg::MODE_ADD, 4'd9, TIME_MAX, 64'd1);        // wraps to deadline 0
        offer(dleq_pkg::MODE_ADD, 4'd12, 64'd1, TIME_MAX);       // wraps to deadline 0
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, TIME_MAX);          // everything due
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, TIME_MAX);          // queue empty again
        offer(dleq_pkg::MODE_ADD, 4'd1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        offer(MODE_UNUSED, 4'd0, '0, '0);
        offer(dleq_pkg::MODE_TICK, 4'd0, '0, '0);
        drain();

        // fill every slot, then let the whole queue expire in one tick
        for (int s = 0; s < dleq_pkg::SLOTS_DEF; s++)
            offer(dleq_pkg::MODE_ADD, 4'(s), 64'($urandom_range(0, 50)), clock_us);
        clock_us += 64'd60;
        offer(dleq_pkg::MODE_TICK, 4'($urandom_range(0, 15)), '0, clock_us);

        // random part: mostly adds and ticks on an advancing clock, some wide noise
        while (items_done < 225)
        begin
            if (items_done == 40 && !hold_issued)
            begin
                hold_req = 1'b1;
                hold_issued = 1'b1;
            end
            if (items_done == 150)
            begin
                drain();
                items_done++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                offer(dleq_pkg::MODE_ADD, 4'($urandom_range(0, 15)),
                      64'($urandom_range(0, 300)), clock_us);
            else if (pick < 55)
                offer(dleq_pkg::MODE_READD, 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 1) == 0) ? '0 : 64'($urandom_range(1, 300)),
                      clock_us);
            else if (pick < 92)
            begin
                clock_us += 64'($urandom_range(0, 120));
                offer(dleq_pkg::MODE_TICK, 4'($urandom_range(0, 15)),
                      64'($urandom_range(0, 300)), clock_us);
            end
            else if (pick < 95)
            begin
                // ignored items, not counted
                offer(MODE_UNUSED, 4'($urandom_range(0, 15)),
                      {$urandom, $urandom}, {$urandom, $urandom});
                continue;
            end
            else
                offer(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                      {$urandom, $urandom}, {$urandom, $urandom});
            items_done++;
        end

        // wait for the tail, then keep clocking for anything stray
        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
